@@ rtl/core/tlqhm_pkg.sv @@
// Shared constants, types and helper functions of the link-quality and hop monitor.
`default_nettype none
package tlqhm_pkg;

   localparam int NODE_LIMIT   = 16;
   localparam int WINDOW_SLOTS = 128;
   localparam int IDX_W        = $clog2(WINDOW_SLOTS);
   localparam int NODE_W       = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
   localparam int ADDR_W       = NODE_W + IDX_W;
   localparam int REM_W        = $clog2(WINDOW_SLOTS + 1);
   localparam int CNT_W        = 16;
   localparam int PHASE_W      = 7;
   localparam int EVAL_PERIOD  = 100;
   localparam int LOSS_SCALE   = 100;
   localparam int PROD_W       = CNT_W + 7;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [CNT_W-1:0] COUNT_CAP   = 16'hFFFF;
   localparam logic [3:0]       HOP_BEACONS = 4'd10;

   localparam logic [1:0] ACT_DATA     = 2'd0;
   localparam logic [1:0] ACT_BEACON   = 2'd1;
   localparam logic [1:0] ACT_ACK      = 2'd2;
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   localparam logic [3:0] CHAN_LOW  = 4'd1;
   localparam logic [3:0] CHAN_MID  = 4'd6;
   localparam logic [3:0] CHAN_HIGH = 4'd11;

   localparam logic CSR_TARGET    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   typedef enum logic [2:0] {
      STATUS_IGNORED   = 3'd0,
      STATUS_UPDATED   = 3'd1,
      STATUS_EVALUATED = 3'd2,
      STATUS_HOP       = 3'd3,
      STATUS_BEACON    = 3'd4,
      STATUS_ACK       = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_ROWCLR,
      ST_ROWSET,
      ST_READ,
      ST_FILL,
      ST_EVAL,
      ST_MUL,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  node_id;
      logic [31:0] pkt_sn;
      logic [3:0]  current_channel;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] frame_number;
      logic [15:0] node_bitmask;
      logic [3:0]  announced_channel;
      logic [3:0]  hop_countdown;
      logic        switch_now;
      logic        is_running;
      logic [7:0]  received_count;
      logic [7:0]  lost_count;
      logic [3:0]  hop_target;
   } result_type;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v < COUNT_CAP) ? v + CNT_W'(1) : v;
   endfunction

   function automatic logic [CNT_W-1:0] drop(input logic [CNT_W-1:0] v);
      return (v != '0) ? v - CNT_W'(1) : v;
   endfunction

   function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
      return (v > CNT_W'(255)) ? 8'hFF : v[7:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/tlqhm_slot_ram.sv @@
// Single-bit slot history memory with one write port and a registered read port.
`default_nettype none
module tlqhm_slot_ram #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/tlqhm_engine.sv @@
// Sequencer that processes one item at a time over the node tables and slot memory.
`default_nettype none
module tlqhm_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire tlqhm_pkg::item_type  item,
   input  wire logic [4:0]           nodes_needed,
   input  wire logic [6:0]           loss_threshold_pct,
   output logic                      idle,
   output logic                      done,
   input  wire logic                 grant,
   output tlqhm_pkg::result_type     result
);

   tlqhm_pkg::state_type state_ff, state_in;

   logic [tlqhm_pkg::NODE_LIMIT-1:0] flags_ff;
   logic                             running_ff;
   logic [tlqhm_pkg::CNT_W-1:0]      rec_ff   [tlqhm_pkg::NODE_LIMIT];
   logic [tlqhm_pkg::CNT_W-1:0]      lost_ff  [tlqhm_pkg::NODE_LIMIT];
   logic [31:0]                      lseq_ff  [tlqhm_pkg::NODE_LIMIT];
   logic [tlqhm_pkg::PHASE_W-1:0]    phase_ff [tlqhm_pkg::NODE_LIMIT];
   logic                             hop_pend_ff;
   logic [3:0]                       hop_chan_ff;
   logic [3:0]                       hop_rem_ff;
   logic [31:0]                      beacon_ff;
   logic                             clr_pend_ff;

   logic [tlqhm_pkg::NODE_W-1:0]     n_ff;
   logic [31:0]                      seq_ff;
   logic [3:0]                       chan_ff;
   logic [tlqhm_pkg::CNT_W-1:0]      wrec_ff;
   logic [tlqhm_pkg::CNT_W-1:0]      wlost_ff;
   logic [tlqhm_pkg::REM_W-1:0]      rem_ff;
   logic [tlqhm_pkg::IDX_W-1:0]      idx_ff;
   logic [tlqhm_pkg::ADDR_W-1:0]     sweep_ff;
   logic [tlqhm_pkg::PROD_W-1:0]     prod_ff;
   tlqhm_pkg::result_type            res_ff;

   logic                             node_ok;
   logic [tlqhm_pkg::NODE_W-1:0]     node_idx;
   logic [tlqhm_pkg::NODE_LIMIT-1:0] flags_new;
   logic [31:0]                      last_seq;
   logic [31:0]                      gap;
   logic                             gap_large;
   logic [tlqhm_pkg::CNT_W-1:0]      fill_rec;
   logic [tlqhm_pkg::CNT_W-1:0]      fill_lost;
   logic                             fill_last;
   logic [tlqhm_pkg::PHASE_W-1:0]    phase_new;
   logic [tlqhm_pkg::CNT_W:0]        total;
   logic [tlqhm_pkg::PROD_W-1:0]     rhs;
   logic                             hop_hit;
   logic [3:0]                       hop_tgt;
   logic [3:0]                       rem_new;
   tlqhm_pkg::result_type            res_start;

   logic                             wr_en;
   logic [tlqhm_pkg::ADDR_W-1:0]     wr_addr;
   logic                             wr_data;
   logic [tlqhm_pkg::ADDR_W-1:0]     rd_addr;
   logic                             rd_bit;

   tlqhm_slot_ram #(
      .ADDR_W (tlqhm_pkg::ADDR_W),
      .DATA_W (1)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bit)
   );

   assign node_ok   = (item.node_id >= 8'd1) && (item.node_id <= 8'(tlqhm_pkg::NODE_LIMIT));
   assign node_idx  = tlqhm_pkg::NODE_W'(item.node_id - 8'd1);
   assign flags_new = flags_ff
                    | (node_ok ? (tlqhm_pkg::NODE_LIMIT'(1) << node_idx) : '0);
   assign last_seq  = lseq_ff[n_ff];
   assign gap       = seq_ff - last_seq;
   assign gap_large = gap > 32'(tlqhm_pkg::WINDOW_SLOTS);
   assign fill_last = rem_ff == tlqhm_pkg::REM_W'(1);
   assign rem_new   = hop_rem_ff - 4'd1;
   assign total     = {1'b0, wrec_ff} + {1'b0, wlost_ff};
   assign phase_new = (phase_ff[n_ff] == tlqhm_pkg::PHASE_W'(tlqhm_pkg::EVAL_PERIOD - 1))
                    ? '0 : phase_ff[n_ff] + tlqhm_pkg::PHASE_W'(1);
   assign rhs       = tlqhm_pkg::PROD_W'(loss_threshold_pct)
                    * tlqhm_pkg::PROD_W'(tlqhm_pkg::WINDOW_SLOTS);
   assign hop_hit   = prod_ff > rhs;
   assign hop_tgt   = (chan_ff == tlqhm_pkg::CHAN_LOW) ? tlqhm_pkg::CHAN_MID :
                      (chan_ff == tlqhm_pkg::CHAN_MID) ? tlqhm_pkg::CHAN_HIGH :
                      tlqhm_pkg::CHAN_LOW;

   always_comb begin
      fill_rec  = wrec_ff;
      fill_lost = wlost_ff;
      if (rd_bit) begin
         fill_rec = tlqhm_pkg::drop(fill_rec);
      end else begin
         fill_lost = tlqhm_pkg::drop(fill_lost);
      end
      if (fill_last) begin
         fill_rec = tlqhm_pkg::bump(fill_rec);
      end else begin
         fill_lost = tlqhm_pkg::bump(fill_lost);
      end
   end

   always_comb begin
      res_start = '0;
      case (item.action)
         tlqhm_pkg::ACT_BEACON: begin
            res_start.status       = tlqhm_pkg::STATUS_BEACON;
            res_start.frame_number = beacon_ff;
            if (hop_pend_ff) begin
               res_start.announced_channel = hop_chan_ff;
               res_start.hop_countdown     = rem_new;
               res_start.switch_now        = (rem_new == '0);
            end
         end
         tlqhm_pkg::ACT_ACK: begin
            res_start.status = tlqhm_pkg::STATUS_ACK;
         end
         default: begin
            res_start.status = tlqhm_pkg::STATUS_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlqhm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wr_en    = 1'b0;
      wr_addr  = {n_ff, idx_ff};
      wr_data  = 1'b0;
      rd_addr  = {n_ff, idx_ff};
      idle     = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         tlqhm_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            if (sweep_ff == '1) begin
               state_in = tlqhm_pkg::ST_IDLE;
            end
         end
         tlqhm_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               if (item.action == tlqhm_pkg::ACT_DATA && node_ok && running_ff) begin
                  state_in = tlqhm_pkg::ST_LOAD;
               end else begin
                  state_in = tlqhm_pkg::ST_DONE;
               end
            end
         end
         tlqhm_pkg::ST_LOAD: begin
            if (last_seq == '0) begin
               wr_en    = 1'b1;
               wr_addr  = {n_ff, seq_ff[tlqhm_pkg::IDX_W-1:0]};
               wr_data  = 1'b1;
               state_in = tlqhm_pkg::ST_EVAL;
            end else if (seq_ff > last_seq) begin
               state_in = gap_large ? tlqhm_pkg::ST_ROWCLR : tlqhm_pkg::ST_READ;
            end else begin
               state_in = tlqhm_pkg::ST_EVAL;
            end
         end
         tlqhm_pkg::ST_ROWCLR: begin
            wr_en = 1'b1;
            if (idx_ff == '1) begin
               state_in = tlqhm_pkg::ST_ROWSET;
            end
         end
         tlqhm_pkg::ST_ROWSET: begin
            wr_en    = 1'b1;
            wr_addr  = {n_ff, seq_ff[tlqhm_pkg::IDX_W-1:0]};
            wr_data  = 1'b1;
            state_in = tlqhm_pkg::ST_EVAL;
         end
         tlqhm_pkg::ST_READ: begin
            state_in = tlqhm_pkg::ST_FILL;
         end
         tlqhm_pkg::ST_FILL: begin
            wr_en    = 1'b1;
            wr_data  = fill_last;
            state_in = fill_last ? tlqhm_pkg::ST_EVAL : tlqhm_pkg::ST_READ;
         end
         tlqhm_pkg::ST_EVAL: begin
            if (total >= (tlqhm_pkg::CNT_W + 1)'(tlqhm_pkg::WINDOW_SLOTS)
                && phase_new == '0) begin
               state_in = tlqhm_pkg::ST_MUL;
            end else begin
               state_in = tlqhm_pkg::ST_DONE;
            end
         end
         tlqhm_pkg::ST_MUL: begin
            state_in = tlqhm_pkg::ST_CMP;
         end
         tlqhm_pkg::ST_CMP: begin
            state_in = tlqhm_pkg::ST_DONE;
         end
         tlqhm_pkg::ST_DONE: begin
            done = 1'b1;
            if (grant) begin
               state_in = clr_pend_ff ? tlqhm_pkg::ST_CLEAR : tlqhm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlqhm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         running_ff  <= 1'b0;
         hop_pend_ff <= 1'b0;
         hop_chan_ff <= '0;
         hop_rem_ff  <= '0;
         beacon_ff   <= '0;
         clr_pend_ff <= 1'b0;
         sweep_ff    <= '0;
         for (int i = 0; i < tlqhm_pkg::NODE_LIMIT; i++) begin
            rec_ff[i]   <= '0;
            lost_ff[i]  <= '0;
            lseq_ff[i]  <= '0;
            phase_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            tlqhm_pkg::ST_CLEAR: begin
               sweep_ff <= sweep_ff + tlqhm_pkg::ADDR_W'(1);
               if (sweep_ff == '1) begin
                  clr_pend_ff <= 1'b0;
               end
            end
            tlqhm_pkg::ST_IDLE: begin
               if (start) begin
                  res_ff  <= res_start;
                  n_ff    <= node_idx;
                  seq_ff  <= item.pkt_sn;
                  chan_ff <= item.current_channel;
                  case (item.action)
                     tlqhm_pkg::ACT_BEACON: begin
                        beacon_ff <= beacon_ff + 32'd1;
                        if (hop_pend_ff) begin
                           hop_rem_ff <= rem_new;
                           if (rem_new == '0) begin
                              hop_pend_ff <= 1'b0;
                           end
                        end
                     end
                     tlqhm_pkg::ACT_ACK: begin
                        flags_ff <= flags_new;
                        if (!running_ff && $countones(flags_new) >= int'(nodes_needed)) begin
                           running_ff <= 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            tlqhm_pkg::ST_LOAD: begin
               if (last_seq == '0) begin
                  wrec_ff       <= tlqhm_pkg::CNT_W'(1);
                  wlost_ff      <= '0;
                  lseq_ff[n_ff] <= seq_ff;
               end else begin
                  wrec_ff  <= rec_ff[n_ff];
                  wlost_ff <= lost_ff[n_ff];
                  if (seq_ff > last_seq) begin
                     lseq_ff[n_ff] <= seq_ff;
                     idx_ff        <= gap_large ? '0
                                    : last_seq[tlqhm_pkg::IDX_W-1:0] + tlqhm_pkg::IDX_W'(1);
                     rem_ff        <= gap[tlqhm_pkg::REM_W-1:0];
                  end
               end
            end
            tlqhm_pkg::ST_ROWCLR: begin
               idx_ff <= idx_ff + tlqhm_pkg::IDX_W'(1);
            end
            tlqhm_pkg::ST_ROWSET: begin
               wrec_ff  <= tlqhm_pkg::CNT_W'(1);
               wlost_ff <= tlqhm_pkg::CNT_W'(tlqhm_pkg::WINDOW_SLOTS - 1);
            end
            tlqhm_pkg::ST_FILL: begin
               wrec_ff  <= fill_rec;
               wlost_ff <= fill_lost;
               rem_ff   <= rem_ff - tlqhm_pkg::REM_W'(1);
               idx_ff   <= idx_ff + tlqhm_pkg::IDX_W'(1);
            end
            tlqhm_pkg::ST_EVAL: begin
               rec_ff[n_ff]          <= wrec_ff;
               lost_ff[n_ff]         <= wlost_ff;
               phase_ff[n_ff]        <= phase_new;
               res_ff.status         <= tlqhm_pkg::STATUS_UPDATED;
               res_ff.received_count <= tlqhm_pkg::sat8(wrec_ff);
               res_ff.lost_count     <= tlqhm_pkg::sat8(wlost_ff);
            end
            tlqhm_pkg::ST_MUL: begin
               prod_ff <= tlqhm_pkg::PROD_W'(wlost_ff) * tlqhm_pkg::PROD_W'(tlqhm_pkg::LOSS_SCALE);
            end
            tlqhm_pkg::ST_CMP: begin
               if (hop_hit) begin
                  res_ff.status     <= tlqhm_pkg::STATUS_HOP;
                  res_ff.hop_target <= hop_tgt;
                  if (!hop_pend_ff) begin
                     hop_pend_ff <= 1'b1;
                     hop_chan_ff <= hop_tgt;
                     hop_rem_ff  <= tlqhm_pkg::HOP_BEACONS;
                  end
                  for (int i = 0; i < tlqhm_pkg::NODE_LIMIT; i++) begin
                     rec_ff[i]   <= '0;
                     lost_ff[i]  <= '0;
                     lseq_ff[i]  <= '0;
                     phase_ff[i] <= '0;
                  end
                  clr_pend_ff <= 1'b1;
                  sweep_ff    <= '0;
               end else begin
                  res_ff.status <= tlqhm_pkg::STATUS_EVALUATED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result              = res_ff;
      result.node_bitmask = 16'(flags_ff);
      result.is_running   = running_ff;
   end

endmodule
`default_nettype wire

@@ rtl/core/tdma_link_quality_hop_monitor.sv @@
// Top level of the link-quality and hop monitor: register port, handshakes and result register.
// An item is taken only while the engine is idle. A beacon, a registration ack or an ignored
// packet goes straight to the done state; a data packet reads then writes the one-bit slot
// memory for each slot between the previous and the new sequence number, then may run the loss
// test, and after a gap larger than the window it sweeps the node's row instead.
// A hop decision, and leaving reset, sweeps the whole 2048-entry slot memory, one entry a
// cycle, during which no item is accepted; register writes are taken at all times. While the
// previous result waits for rsp_ready, the engine holds its finished item in its done state.
`default_nettype none
module tdma_link_quality_hop_monitor (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_action,
   input  wire logic [7:0]                       req_node_id,
   input  wire logic [31:0]                      req_pkt_sn,
   input  wire logic [3:0]                       req_current_channel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [2:0]                            rsp_status,
   output logic [31:0]                           rsp_frame_number,
   output logic [15:0]                           rsp_node_bitmask,
   output logic [3:0]                            rsp_announced_channel,
   output logic [3:0]                            rsp_hop_countdown,
   output logic                                  rsp_switch_now,
   output logic                                  rsp_is_running,
   output logic [7:0]                            rsp_received_count,
   output logic [7:0]                            rsp_lost_count,
   output logic [3:0]                            rsp_hop_target,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [tlqhm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic [4:0]            target_ff;
   logic [6:0]            thresh_ff;
   logic                  rsp_valid_ff;
   tlqhm_pkg::result_type rsp_ff;

   tlqhm_pkg::item_type   item;
   tlqhm_pkg::result_type eng_result;
   logic                  eng_idle;
   logic                  eng_done;
   logic                  load;
   logic                  csr_wr;

   assign item.action          = req_action;
   assign item.node_id         = req_node_id;
   assign item.pkt_sn          = req_pkt_sn;
   assign item.current_channel = req_current_channel;

   assign req_ready = eng_idle;
   assign load      = eng_done && (!rsp_valid_ff || rsp_ready);

   tlqhm_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .start              (req_valid && eng_idle),
      .item               (item),
      .nodes_needed       (target_ff),
      .loss_threshold_pct (thresh_ff),
      .idle               (eng_idle),
      .done               (eng_done),
      .grant              (load),
      .result             (eng_result)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 5'd1;
         thresh_ff <= 7'd10;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            tlqhm_pkg::CSR_TARGET:    target_ff <= csr_pwdata[4:0];
            tlqhm_pkg::CSR_THRESHOLD: thresh_ff <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         tlqhm_pkg::CSR_TARGET:    csr_prdata = 32'(target_ff);
         tlqhm_pkg::CSR_THRESHOLD: csr_prdata = 32'(thresh_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= eng_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_frame_number      = rsp_ff.frame_number;
   assign rsp_node_bitmask      = rsp_ff.node_bitmask;
   assign rsp_announced_channel = rsp_ff.announced_channel;
   assign rsp_hop_countdown     = rsp_ff.hop_countdown;
   assign rsp_switch_now        = rsp_ff.switch_now;
   assign rsp_is_running        = rsp_ff.is_running;
   assign rsp_received_count    = rsp_ff.received_count;
   assign rsp_lost_count        = rsp_ff.lost_count;
   assign rsp_hop_target        = rsp_ff.hop_target;

endmodule
`default_nettype wire

@@ rtl/core/tlqhm_checker.sv @@
// Port-level checker of the link-quality and hop monitor and its bind statement.
`default_nettype none
module tlqhm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_frame_number,
   input wire logic [3:0]  rsp_hop_countdown,
   input wire logic        rsp_switch_now,
   input wire logic [7:0]  rsp_received_count,
   input wire logic [7:0]  rsp_lost_count,
   input wire logic [3:0]  rsp_hop_target
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result item changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= tlqhm_pkg::STATUS_ACK)
      else $error("result status out of range");

   a_beacon_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tlqhm_pkg::STATUS_BEACON |->
         rsp_frame_number == '0 && rsp_hop_countdown == '0 && !rsp_switch_now)
      else $error("beacon fields set on a non-beacon item");

   a_hop_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tlqhm_pkg::STATUS_HOP |->
         rsp_hop_target == tlqhm_pkg::CHAN_LOW || rsp_hop_target == tlqhm_pkg::CHAN_MID
         || rsp_hop_target == tlqhm_pkg::CHAN_HIGH)
      else $error("hop target is not a hop channel");

   a_counts_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tlqhm_pkg::STATUS_IGNORED
                    || rsp_status == tlqhm_pkg::STATUS_BEACON
                    || rsp_status == tlqhm_pkg::STATUS_ACK) |->
         rsp_received_count == '0 && rsp_lost_count == '0)
      else $error("window counts set on a non-data item");

endmodule

bind tdma_link_quality_hop_monitor tlqhm_checker u_tlqhm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_frame_number   (rsp_frame_number),
   .rsp_hop_countdown  (rsp_hop_countdown),
   .rsp_switch_now     (rsp_switch_now),
   .rsp_received_count (rsp_received_count),
   .rsp_lost_count     (rsp_lost_count),
   .rsp_hop_target     (rsp_hop_target)
);
`default_nettype wire
